// ----- src/dccd_pkg.sv -----
// shared constants and codes for the decaying counter cache directory
package dccd_pkg;

   localparam int ENTRIES      = 8;
   localparam int COUNTER_BITS = 8;
   localparam int KEY_W        = 32;
   localparam int HANDLE_W     = 32;
   localparam int SLOT_W       = 3;
   localparam int IDX_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam logic [IDX_W-1:0]        IDX_LAST = IDX_W'(ENTRIES - 1);
   localparam logic [COUNTER_BITS-1:0] CNT_MAX  = '1;
   localparam logic [COUNTER_BITS-1:0] CNT_ZERO = '0;
   localparam logic [COUNTER_BITS-1:0] CNT_ONE  = COUNTER_BITS'(1);
   localparam logic [KEY_W-1:0]        KEY_NONE = '0;

   typedef enum logic {
      KIND_LOOKUP = 1'b0,
      KIND_INSERT = 1'b1
   } kind_type;

endpackage

// ----- src/decaying_counter_cache_directory_unit.sv -----
// decaying counter cache directory: entry store, walk sequencer and result register
//
// usage
//   request channel (req_valid / req_stall / req_kind, req_item_key, req_data_handle):
//   a transaction is taken when req_valid is high and req_stall low. req_kind selects a
//   lookup of req_item_key or an insert of req_item_key with req_data_handle.
//   result channel (rsp_valid / rsp_stall / rsp_found, rsp_stored, rsp_slot,
//   rsp_hit_handle): exactly one result transaction per request.
// walk
//   one entry is visited per cycle by a single compare / counter update unit, walking
//   from entry 0 upward and stopping early on a hit (lookup) or a free entry (insert).
//   one request is in work at a time: the next request can be taken in the cycle after
//   the previous result has been taken.
// reset
//   synchronous active-high reset empties all entries (keys, counters, handles zero)
//   and returns the sequencer to idle; no clearing pass is needed.
// stall
//   while rsp_stall is high the result is held stable and req_stall stays high.
module decaying_counter_cache_directory_unit
   import dccd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_kind,
   input  logic [KEY_W-1:0]    req_item_key,
   input  logic [HANDLE_W-1:0] req_data_handle,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_found,
   output logic                rsp_stored,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic [HANDLE_W-1:0] rsp_hit_handle
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   // sequencer
   state_type              state_ff,  state_in;
   logic [IDX_W-1:0]       idx_ff,    idx_in;

   // captured request
   kind_type               kind_ff,   kind_in;
   logic [KEY_W-1:0]       key_ff,    key_in;
   logic [HANDLE_W-1:0]    handle_ff, handle_in;

   // entry store
   logic [KEY_W-1:0]        keys_ff     [ENTRIES];
   logic [KEY_W-1:0]        keys_in     [ENTRIES];
   logic [COUNTER_BITS-1:0] counters_ff [ENTRIES];
   logic [COUNTER_BITS-1:0] counters_in [ENTRIES];
   logic [HANDLE_W-1:0]     handles_ff  [ENTRIES];
   logic [HANDLE_W-1:0]     handles_in  [ENTRIES];

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   found_ff,     found_in;
   logic                   stored_ff,    stored_in;
   logic [SLOT_W-1:0]      slot_ff,      slot_in;
   logic [HANDLE_W-1:0]    hit_handle_ff, hit_handle_in;

   // shared walk unit signals
   logic [KEY_W-1:0]        cur_key;
   logic [COUNTER_BITS-1:0] cur_cnt;
   logic [COUNTER_BITS-1:0] dec_cnt;
   logic                    key_hit;
   logic                    last_entry;
   logic [IDX_W+SLOT_W-1:0] idx_wide;

   assign cur_key    = keys_ff[idx_ff];
   assign cur_cnt    = counters_ff[idx_ff];
   assign dec_cnt    = (cur_cnt != CNT_ZERO) ? (cur_cnt - CNT_ONE) : cur_cnt;
   assign key_hit    = (key_ff != KEY_NONE) && (cur_key == key_ff);
   assign last_entry = (idx_ff == IDX_LAST);
   // slot carries the low bits of the entry index
   assign idx_wide   = {{SLOT_W{1'b0}}, idx_ff};

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      handle_in     = handle_ff;
      keys_in       = keys_ff;
      counters_in   = counters_ff;
      handles_in    = handles_ff;
      rsp_valid_in  = rsp_valid_ff;
      found_in      = found_ff;
      stored_in     = stored_ff;
      slot_in       = slot_ff;
      hit_handle_in = hit_handle_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // capture the request and clear the result fields
               kind_in       = kind_type'(req_kind);
               key_in        = req_item_key;
               handle_in     = req_data_handle;
               idx_in        = '0;
               found_in      = 1'b0;
               stored_in     = 1'b0;
               slot_in       = '0;
               hit_handle_in = '0;
               state_in      = ST_WALK;
            end
         end

         ST_WALK: begin
            if (kind_ff == KIND_LOOKUP) begin
               if (key_hit) begin
                  // hit: bump counter with saturation and stop
                  if (cur_cnt != CNT_MAX) begin
                     counters_in[idx_ff] = cur_cnt + CNT_ONE;
                  end
                  found_in      = 1'b1;
                  slot_in       = idx_wide[SLOT_W-1:0];
                  hit_handle_in = handles_ff[idx_ff];
                  rsp_valid_in  = 1'b1;
                  state_in      = ST_DONE;
               end else begin
                  // passed entry decays, and an occupied one that reaches zero is evicted
                  counters_in[idx_ff] = dec_cnt;
                  if ((dec_cnt == CNT_ZERO) && (cur_key != KEY_NONE)) begin
                     keys_in[idx_ff]    = KEY_NONE;
                     handles_in[idx_ff] = '0;
                  end
                  if (last_entry) begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_DONE;
                  end else begin
                     idx_in = IDX_W'(idx_ff + 1'b1);
                  end
               end
            end else begin
               if (cur_cnt == CNT_ZERO) begin
                  // free entry: claim it
                  counters_in[idx_ff] = CNT_ONE;
                  keys_in[idx_ff]     = key_ff;
                  handles_in[idx_ff]  = handle_ff;
                  stored_in           = 1'b1;
                  slot_in             = idx_wide[SLOT_W-1:0];
                  rsp_valid_in        = 1'b1;
                  state_in            = ST_DONE;
               end else if (last_entry) begin
                  // no free entry, insert dropped
                  rsp_valid_in = 1'b1;
                  state_in     = ST_DONE;
               end else begin
                  idx_in = IDX_W'(idx_ff + 1'b1);
               end
            end
         end

         ST_DONE: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            rsp_valid_in = 1'b0;
            state_in     = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            keys_ff[i]     <= KEY_NONE;
            counters_ff[i] <= CNT_ZERO;
            handles_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         keys_ff      <= keys_in;
         counters_ff  <= counters_in;
         handles_ff   <= handles_in;
      end
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      handle_ff     <= handle_in;
      found_ff      <= found_in;
      stored_ff     <= stored_in;
      slot_ff       <= slot_in;
      hit_handle_ff <= hit_handle_in;
   end

   // requests are taken only while idle
   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = found_ff;
   assign rsp_stored     = stored_ff;
   assign rsp_slot       = slot_ff;
   assign rsp_hit_handle = hit_handle_ff;

   // a pending result always blocks new requests
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while a result is pending");

   // an accepted request starts the walk at entry zero
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_WALK && idx_ff == '0))
      else $error("walk did not start at entry zero");

   // a result may report a lookup hit or a stored insert, never both
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_stored))
      else $error("result reports both hit and store");

   // only a hit carries a handle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_hit_handle == '0))
      else $error("handle reported without a hit");

   // a stored insert leaves its entry with counter one
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && state_in == ST_DONE && stored_in)
         |=> (counters_ff[$past(idx_ff)] == CNT_ONE))
      else $error("inserted entry counter not one");

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the decaying counter cache directory unit
module testbench
   import dccd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD      = 6;
   localparam int RESET_CYCLES     = 9;
   localparam int HOT_LOOKUPS      = 300;
   localparam int RANDOM_PER_PHASE = 410;
   localparam int POOL_SIZE        = 6;
   localparam int PHASES           = 4;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int DRAIN_CYCLES     = 20;

   // idle and stall odds per phase, in percent: none, sender, receiver, both
   localparam int SEND_IDLE_PCT [PHASES] = '{0, 76, 0, 27};
   localparam int RECV_STALL_PCT[PHASES] = '{0, 0, 76, 27};

   typedef struct {
      kind_type            kind;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
   } dir_request_type;

   typedef struct packed {
      logic                found;
      logic                stored;
      logic [SLOT_W-1:0]   slot;
      logic [HANDLE_W-1:0] hit_handle;
   } dir_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_kind = 1'b0;
   logic [KEY_W-1:0]    req_item_key = '0;
   logic [HANDLE_W-1:0] req_data_handle = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_found;
   logic                rsp_stored;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [HANDLE_W-1:0] rsp_hit_handle;

   // request transaction taken at the last rising edge, seen by the driver
   logic req_hs = 1'b0;

   dir_request_type queued_requests[$];
   dir_result_type  predicted_results[$];

   int sender_idle_pct = 0;
   int recv_stall_pct  = 0;
   int failures        = 0;
   int idle_cycles     = 0;

   // shadow copy of the directory contents
   logic [KEY_W-1:0]        dir_key   [ENTRIES];
   logic [COUNTER_BITS-1:0] dir_count [ENTRIES];
   logic [HANDLE_W-1:0]     dir_handle[ENTRIES];

   logic [KEY_W-1:0] key_pool[POOL_SIZE];

   decaying_counter_cache_directory_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_item_key    (req_item_key),
      .req_data_handle (req_data_handle),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_stored      (rsp_stored),
      .rsp_slot        (rsp_slot),
      .rsp_hit_handle  (rsp_hit_handle)
   );

   initial begin
      forever #HALF_PERIOD clock = ~clock;
   end

   // directory starts empty, same as after reset
   initial begin
      for (int i = 0; i < ENTRIES; i++) begin
         dir_key[i]    = KEY_NONE;
         dir_count[i]  = CNT_ZERO;
         dir_handle[i] = '0;
      end
   end

   // walk the shadow directory for one request and update it in place
   function automatic dir_result_type walk_directory(kind_type kind, logic [KEY_W-1:0] key,
                                                     logic [HANDLE_W-1:0] handle);
      dir_result_type res;
      bit             done;
      res  = '0;
      done = 1'b0;
      if (kind == KIND_LOOKUP) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (!done) begin
               if (key != KEY_NONE && dir_key[i] == key) begin
                  // hit: bump the use counter, saturating, and stop the walk
                  if (dir_count[i] != CNT_MAX)
                     dir_count[i] = dir_count[i] + CNT_ONE;
                  res.found      = 1'b1;
                  res.slot       = SLOT_W'(i);
                  res.hit_handle = dir_handle[i];
                  done           = 1'b1;
               end else begin
                  // passed over: decay, and evict an occupied entry that hits zero
                  if (dir_count[i] != CNT_ZERO)
                     dir_count[i] = dir_count[i] - CNT_ONE;
                  if (dir_count[i] == CNT_ZERO && dir_key[i] != KEY_NONE) begin
                     dir_key[i]    = KEY_NONE;
                     dir_handle[i] = '0;
                  end
               end
            end
         end
      end else begin
         // insert takes the lowest entry with a zero counter, else it is dropped
         for (int i = 0; i < ENTRIES; i++) begin
            if (!done && dir_count[i] == CNT_ZERO) begin
               dir_count[i]  = CNT_ONE;
               dir_key[i]    = key;
               dir_handle[i] = handle;
               res.stored    = 1'b1;
               res.slot      = SLOT_W'(i);
               done          = 1'b1;
            end
         end
      end
      return res;
   endfunction

   function automatic logic [KEY_W-1:0] fresh_key();
      logic [KEY_W-1:0] k;
      k = $urandom;
      if (k == KEY_NONE)
         k = KEY_W'(1);
      return k;
   endfunction

   task automatic queue_request(kind_type kind, logic [KEY_W-1:0] key,
                                logic [HANDLE_W-1:0] handle);
      dir_request_type r;
      r.kind   = kind;
      r.key    = key;
      r.handle = handle;
      queued_requests.push_back(r);
   endtask

   task automatic check_field(string field, logic [HANDLE_W-1:0] want,
                              logic [HANDLE_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", field, want, got);
         failures++;
      end
   endtask

   // known sequence from an empty directory: extremes, key zero, duplicates,
   // eviction on the walk, a full directory with a dropped insert
   task automatic queue_directed();
      queue_request(KIND_LOOKUP, 32'h0000_0001, 32'hFFFF_FFFF);
      queue_request(KIND_LOOKUP, KEY_NONE,      32'h0000_0000);
      queue_request(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_request(KIND_INSERT, 32'h0000_0001, 32'h0000_0000);
      queue_request(KIND_INSERT, KEY_NONE,      32'h5A5A_5A5A);
      queue_request(KIND_INSERT, 32'hA5A5_A5A5, 32'h0000_0000);
      queue_request(KIND_INSERT, 32'h0000_0001, 32'h1234_5678);
      // hits the lower duplicate, evicts the entry in front of it
      queue_request(KIND_LOOKUP, 32'h0000_0001, 32'hFFFF_FFFF);
      // misses on the evicted key, decays everything
      queue_request(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
      queue_request(KIND_LOOKUP, KEY_NONE,      32'hFFFF_FFFF);
      // fill every entry
      queue_request(KIND_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
      queue_request(KIND_INSERT, 32'h0000_0002, 32'h0000_0001);
      queue_request(KIND_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_request(KIND_INSERT, 32'hDEAD_BEEF, 32'h7FFF_FFFF);
      queue_request(KIND_INSERT, 32'h0001_0000, 32'hC3C3_C3C3);
      queue_request(KIND_INSERT, 32'hFFFF_FFFE, 32'h3C3C_3C3C);
      queue_request(KIND_INSERT, 32'h1357_9BDF, 32'hFFFF_FFFE);
      queue_request(KIND_INSERT, 32'h2468_ACE0, 32'h0F0F_F0F0);
      // no free entry left
      queue_request(KIND_INSERT, 32'h0BAD_F00D, 32'h1111_1111);
      // hit on the last entry after a full walk
      queue_request(KIND_LOOKUP, 32'h2468_ACE0, 32'h0000_0000);
   endtask

   // insert one key and hammer it until its counter saturates
   task automatic queue_hot_key();
      logic [KEY_W-1:0] hot;
      hot = fresh_key();
      queue_request(KIND_INSERT, hot, $urandom);
      repeat (HOT_LOOKUPS) queue_request(KIND_LOOKUP, hot, $urandom);
   endtask

   // mostly keys from a small rotating pool so lookups hit, with some strays
   task automatic queue_random(int count);
      int               pick;
      logic [KEY_W-1:0] pool_key;
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = fresh_key();
      repeat (count) begin
         if ($urandom_range(9) == 0)
            key_pool[$urandom_range(POOL_SIZE - 1)] = fresh_key();
         pick     = $urandom_range(99);
         pool_key = key_pool[$urandom_range(POOL_SIZE - 1)];
         if (pick < 40)
            queue_request(KIND_INSERT, pool_key, $urandom);
         else if (pick < 85)
            queue_request(KIND_LOOKUP, pool_key, $urandom);
         else if (pick < 95)
            queue_request(KIND_LOOKUP, fresh_key(), $urandom);
         else
            queue_request(KIND_INSERT, fresh_key(), $urandom);
      end
   endtask

   // driver: new request transaction and receiver stall at the falling edge
   always @(negedge clock) begin
      dir_request_type outgoing;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         // a shown request stays put until it is taken
         if (!req_valid || req_hs) begin
            if (queued_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               outgoing = queued_requests.pop_front();
               req_valid       <= 1'b1;
               req_kind        <= outgoing.kind;
               req_item_key    <= outgoing.key;
               req_data_handle <= outgoing.handle;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: predict on each taken request, check each taken result
   always @(posedge clock) begin
      dir_result_type want;
      if (reset) begin
         req_hs <= 1'b0;
      end else begin
         req_hs <= req_valid && !req_stall;
         if (req_valid && !req_stall)
            predicted_results.push_back(walk_directory(kind_type'(req_kind), req_item_key,
                                                       req_data_handle));
         if (rsp_valid && !rsp_stall) begin
            if (predicted_results.size() == 0) begin
               $error("result transaction with no request outstanding");
               failures++;
            end else begin
               want = predicted_results.pop_front();
               check_field("found",      HANDLE_W'(want.found),  HANDLE_W'(rsp_found));
               check_field("stored",     HANDLE_W'(want.stored), HANDLE_W'(rsp_stored));
               check_field("slot",       HANDLE_W'(want.slot),   HANDLE_W'(rsp_slot));
               check_field("hit_handle", want.hit_handle,        rsp_hit_handle);
            end
         end
      end
   end

   // watchdog: too long without any transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      queue_directed();
      queue_hot_key();
      for (int p = 0; p < PHASES; p++) begin
         sender_idle_pct = SEND_IDLE_PCT[p];
         recv_stall_pct  = RECV_STALL_PCT[p];
         queue_random(RANDOM_PER_PHASE);
         while (queued_requests.size() != 0)
            @(posedge clock);
      end
      // let the last request through and its result come back
      while (queued_requests.size() != 0 || req_valid || predicted_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
